### design/mpct_pkg.sv
`default_nettype none
package mpct_pkg;

    // Reset values of the wrap bounds
    localparam int WIDTH_RESET  = 720;
    localparam int HEIGHT_RESET = 480;

    // Header bit positions
    localparam int SYNC_POS    = 3;
    localparam int X_SIGN_POS  = 4;
    localparam int Y_SIGN_POS  = 5;
    localparam int LEFT_POS    = 0;

    // Packet byte positions
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;

    // Register indexes (address bit 2 selects)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WRAP
    } mpct_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // request taken this cycle
        logic wrap_start;   // launch both wrap units
        logic wrap_finish;  // commit wrapped cursor and load result
    } mpct_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic third_byte;   // next byte completes a packet
        logic wrap_done;    // both wrap units finished
    } mpct_status_t;

endpackage
`default_nettype wire

### design/mpct_wrap.sv
`default_nettype none
module mpct_wrap #(
    parameter int W = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [W+1:0] value,
    input  wire logic [W-1:0]       bound,
    output logic                    done,
    output logic [W-1:0]            result
);
    localparam int CNT_BITS = $clog2(W + 2);
    localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(W + 1);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [W:0]          mag_reg, mag_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic [W:0]          rem_shift;
    logic [W+1:0]        neg_value;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // One restoring remainder step per cycle on the magnitude
    always_comb
    begin
        neg_value = -value;
        rem_shift = {rem_reg, mag_reg[W]};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            neg_next  = value[W+1];
            mag_next  = value[W+1] ? neg_value[W:0] : value[W:0];
            rem_next  = '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
            mag_next = {mag_reg[W-1:0], 1'b0};
            if (rem_shift >= {1'b0, bound})
                rem_next = W'(rem_shift - {1'b0, bound});
            else
                rem_next = rem_shift[W-1:0];
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    // True modulo: negative values fold back from the bound
    assign done = busy_reg && (cnt_reg == '0);

    always_comb
    begin
        if (bound == '0)
            result = '0;
        else if (neg_reg && (rem_reg != '0))
            result = bound - rem_reg;
        else
            result = rem_reg;
    end

endmodule
`default_nettype wire

### design/mpct_datapath.sv
`default_nettype none
module mpct_datapath
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mpct_cmd_t             cmd,
    output mpct_status_t               status,
    input  wire logic [7:0]            mouse_byte,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_sel,
    input  wire logic [31:0]           cfg_wdata,
    output logic [31:0]                cfg_rdata,
    output logic                       packet_complete,
    output logic                       resync_request,
    output logic                       erase_old,
    output logic [COORD_BITS-1:0]      old_x,
    output logic [COORD_BITS-1:0]      old_y,
    output logic [COORD_BITS-1:0]      new_x,
    output logic [COORD_BITS-1:0]      new_y,
    output logic [2:0]                 buttons
);
    localparam int CB = COORD_BITS;

    logic [CB-1:0] width_reg, height_reg;
    logic [1:0]    pos_reg, pos_next;
    logic [7:0]    header_reg, header_next;
    logic [7:0]    xbyte_reg, xbyte_next;
    logic [CB-1:0] cur_x_reg, cur_x_next;
    logic [CB-1:0] cur_y_reg, cur_y_next;

    logic          complete_reg, complete_next;
    logic          resync_reg, resync_next;
    logic          erase_reg, erase_next;
    logic [CB-1:0] old_x_reg, old_x_next;
    logic [CB-1:0] old_y_reg, old_y_next;
    logic [CB-1:0] new_x_reg, new_x_next;
    logic [CB-1:0] new_y_reg, new_y_next;
    logic [2:0]    btn_reg, btn_next;

    logic signed [8:0]    dx, dy;
    logic signed [CB+1:0] sum_x, sum_y;
    logic                 done_x, done_y;
    logic [CB-1:0]        wrap_x, wrap_y;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CB'(WIDTH_RESET);
            height_reg <= CB'(HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            if (cfg_sel == REG_WIDTH)
                width_reg <= cfg_wdata[CB-1:0];
            else
                height_reg <= cfg_wdata[CB-1:0];
        end
    end

    assign cfg_rdata = (cfg_sel == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    // Packet and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HEADER;
            header_reg <= '0;
            xbyte_reg  <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            xbyte_reg  <= xbyte_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        complete_reg <= complete_next;
        resync_reg   <= resync_next;
        erase_reg    <= erase_next;
        old_x_reg    <= old_x_next;
        old_y_reg    <= old_y_next;
        new_x_reg    <= new_x_next;
        new_y_reg    <= new_y_next;
        btn_reg      <= btn_next;
    end

    // Signed deltas; y moves opposite to the mouse
    assign dx    = {header_reg[X_SIGN_POS], xbyte_reg};
    assign dy    = {header_reg[Y_SIGN_POS], mouse_byte};
    assign sum_x = $signed({2'b00, cur_x_reg}) + (CB+2)'(dx);
    assign sum_y = $signed({2'b00, cur_y_reg}) - (CB+2)'(dy);

    mpct_wrap #(.W(CB)) u_wrap_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.wrap_start),
        .value  (sum_x),
        .bound  (width_reg),
        .done   (done_x),
        .result (wrap_x)
    );

    mpct_wrap #(.W(CB)) u_wrap_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.wrap_start),
        .value  (sum_y),
        .bound  (height_reg),
        .done   (done_y),
        .result (wrap_y)
    );

    assign status.third_byte = pos_reg[1];
    assign status.wrap_done  = done_x && done_y;

    // Byte handling and result loading
    always_comb
    begin
        pos_next      = pos_reg;
        header_next   = header_reg;
        xbyte_next    = xbyte_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        complete_next = complete_reg;
        resync_next   = resync_reg;
        erase_next    = erase_reg;
        old_x_next    = old_x_reg;
        old_y_next    = old_y_reg;
        new_x_next    = new_x_reg;
        new_y_next    = new_y_reg;
        btn_next      = btn_reg;

        if (cmd.accept && !pos_reg[1])
        begin
            // Header or x byte: result shows the unchanged cursor
            complete_next = 1'b0;
            resync_next   = 1'b0;
            erase_next    = 1'b0;
            btn_next      = '0;
            old_x_next    = cur_x_reg;
            old_y_next    = cur_y_reg;
            new_x_next    = cur_x_reg;
            new_y_next    = cur_y_reg;
            if (pos_reg == POS_HEADER)
            begin
                if (!mouse_byte[SYNC_POS])
                    resync_next = 1'b1;
                else
                begin
                    header_next = mouse_byte;
                    pos_next    = POS_X;
                end
            end
            else
            begin
                xbyte_next = mouse_byte;
                pos_next   = 2'd2;
            end
        end
        else if (cmd.wrap_finish)
        begin
            complete_next = 1'b1;
            resync_next   = 1'b0;
            erase_next    = !header_reg[LEFT_POS];
            btn_next      = header_reg[2:0];
            old_x_next    = cur_x_reg;
            old_y_next    = cur_y_reg;
            new_x_next    = wrap_x;
            new_y_next    = wrap_y;
            cur_x_next    = wrap_x;
            cur_y_next    = wrap_y;
            pos_next      = POS_HEADER;
        end
    end

    assign packet_complete = complete_reg;
    assign resync_request  = resync_reg;
    assign erase_old       = erase_reg;
    assign old_x           = old_x_reg;
    assign old_y           = old_y_reg;
    assign new_x           = new_x_reg;
    assign new_y           = new_y_reg;
    assign buttons         = btn_reg;

endmodule
`default_nettype wire

### design/mpct_ctrl.sv
`default_nettype none
module mpct_ctrl
    import mpct_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    input  wire mpct_status_t status,
    output mpct_cmd_t         cmd
);
    mpct_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_stall        = 1'b1;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                // Take a request once the result slot is free or draining
                in_stall   = out_valid_reg && out_stall;
                cmd.accept = in_valid && !in_stall;
                if (cmd.accept)
                begin
                    if (status.third_byte)
                    begin
                        cmd.wrap_start = 1'b1;
                        state_next     = ST_WRAP;
                    end
                    else
                        out_valid_next = 1'b1;
                end
            end
            ST_WRAP:
            begin
                if (status.wrap_done)
                begin
                    cmd.wrap_finish = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### design/mouse_packet_cursor_tracker.sv
// Header and x bytes give their result in the cycle after acceptance;
// the third byte gives it once the bit-serial modulo units that wrap x and y
// in parallel have finished and the result register is loaded.
// Throughput: header and x bytes one per cycle unless a result stalls; a third byte
// holds off the next request until x and y are wrapped.
// Reset: asynchronous, active low; bounds return to 720 and 480, cursor to 0.
`default_nettype none
module mouse_packet_cursor_tracker
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            mouse_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       packet_complete,
    output logic                       resync_request,
    output logic                       erase_old,
    output logic [COORD_BITS-1:0]      old_x,
    output logic [COORD_BITS-1:0]      old_y,
    output logic [COORD_BITS-1:0]      new_x,
    output logic [COORD_BITS-1:0]      new_y,
    output logic [2:0]                 buttons,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    mpct_cmd_t    cmd;
    mpct_status_t status;
    logic         cfg_write;

    // Register write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    mpct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mpct_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mouse_byte      (mouse_byte),
        .cfg_write       (cfg_write),
        .cfg_sel         (paddr[2]),
        .cfg_wdata       (pwdata),
        .cfg_rdata       (prdata),
        .packet_complete (packet_complete),
        .resync_request  (resync_request),
        .erase_old       (erase_old),
        .old_x           (old_x),
        .old_y           (old_y),
        .new_x           (new_x),
        .new_y           (new_y),
        .buttons         (buttons)
    );

endmodule
`default_nettype wire

### design/mpct_checker.sv
`default_nettype none
module mpct_checker #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  packet_complete,
    input  wire logic                  resync_request,
    input  wire logic                  erase_old,
    input  wire logic [COORD_BITS-1:0] old_x,
    input  wire logic [COORD_BITS-1:0] old_y,
    input  wire logic [COORD_BITS-1:0] new_x,
    input  wire logic [COORD_BITS-1:0] new_y,
    input  wire logic [2:0]            buttons
);
    // Held result keeps its cursor
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_x) && $stable(new_y))
        else $error("stalled result changed");

    // A finished packet never also asks for resync
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(packet_complete && resync_request))
        else $error("complete and resync together");

    // Unfinished packet leaves the cursor alone
    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !packet_complete |-> new_x == old_x && new_y == old_y
            && buttons == 3'd0 && !erase_old)
        else $error("cursor moved without a packet");

    // Erase follows the left button
    a_erase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_complete |-> erase_old == !buttons[0])
        else $error("erase does not match left button");

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .packet_complete (packet_complete),
    .resync_request  (resync_request),
    .erase_old       (erase_old),
    .old_x           (old_x),
    .old_y           (old_y),
    .new_x           (new_x),
    .new_y           (new_y),
    .buttons         (buttons)
);
`default_nettype wire
